FILE: src/ssd_pkg.sv
// package for the sample standard deviation block
// holds payload structs, widths and controller/datapath command and status types; no dependencies
package ssd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int STD_W    = 25;
    localparam int COUNT_W  = 11;
    localparam int SUM_W    = 35;
    localparam int ACC_W    = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } ssd_in_t;

    typedef struct packed {
        logic [STD_W-1:0]   std_dev;
        logic [COUNT_W-1:0] sample_count;
        logic               overflow;
    } ssd_out_t;

    // commands from controller to datapath
    typedef struct packed {
        logic store;      // accept a sample transfer
        logic div_start;  // start a divider run
        logic div_var;    // 1: divide accumulator by count-1, 0: sum by count
        logic pass_start; // start deviation pass
        logic sqrt_start; // start square root
        logic clear;      // clear set state
    } ssd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic pass_done;
        logic sqrt_done;
        logic enough;     // at least two samples
    } ssd_stat_t;

endpackage

FILE: src/ssd_ram.sv
// generic single-port ram with registered read
// no dependencies
module ssd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/ssd_datapath.sv
// datapath: sample store, running sums, serial divider and square root
// depends on ssd_pkg and ssd_ram
module ssd_datapath #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ssd_pkg::ssd_in_t  in_data,
    input  ssd_pkg::ssd_cmd_t cmd,
    output ssd_pkg::ssd_stat_t stat,
    output ssd_pkg::ssd_out_t res
);
    import ssd_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SAMPLES);
    localparam int DIV_STEPS = ACC_W;
    localparam int SQRT_STEPS = ACC_W / 2;
    // deviation magnitude never exceeds the span of two samples
    localparam int DEV_W = SAMPLE_W + 1;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic drop_reg, drop_next;
    logic signed [SUM_W-1:0] mean_reg, mean_next;

    // pass control
    logic pass_busy_reg, pass_busy_next;
    logic [COUNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic rd_vld_reg, rd_vld_next;
    logic pass_done_reg, pass_done_next;
    logic signed [DEV_W:0] dev_reg, dev_next;
    logic dev_vld_reg, dev_vld_next;
    logic [2*DEV_W-1:0] sq_reg, sq_next;
    logic sq_vld_reg, sq_vld_next;

    // divider
    logic div_busy_reg, div_busy_next;
    logic div_done_reg, div_done_next;
    logic [6:0] div_cnt_reg, div_cnt_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [COUNT_W:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] dvs_reg, dvs_next;
    logic div_neg_reg, div_neg_next;
    logic div_var_reg, div_var_next;

    // square root
    logic sqrt_busy_reg, sqrt_busy_next;
    logic sqrt_done_reg, sqrt_done_next;
    logic [5:0] sqrt_cnt_reg, sqrt_cnt_next;
    logic [ACC_W-1:0] rad_reg, rad_next;
    logic [ACC_W/2+1:0] srem_reg, srem_next;
    logic [ACC_W/2-1:0] root_reg, root_next;
    logic [STD_W-1:0] std_reg, std_next;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic keep;

    logic [COUNT_W:0] rem_shift, rem_sub;
    logic [ACC_W/2+1:0] srem_shift, trial;
    logic [SUM_W-1:0] sum_mag;
    logic [DEV_W-1:0] dev_mag;

    assign keep = cmd.store && (count_reg < MAX_CNT);
    assign ram_we = keep;
    assign ram_addr = keep ? count_reg[AW-1:0] : rd_idx_reg[AW-1:0];

    ssd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_data.sample),
        .rdata (ram_rdata)
    );

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dev_mag = dev_reg[DEV_W] ? DEV_W'(-dev_reg) : DEV_W'(dev_reg);
    assign rem_shift = {rem_reg[COUNT_W-1:0], quo_reg[ACC_W-1]};
    assign rem_sub = rem_shift - {1'b0, dvs_reg};
    assign srem_shift = {srem_reg[ACC_W/2-1:0], rad_reg[ACC_W-1:ACC_W-2]};
    assign trial = {root_reg, 2'b01};

    always_comb
    begin
        count_next = count_reg;
        sum_next = sum_reg;
        acc_next = acc_reg;
        drop_next = drop_reg;
        mean_next = mean_reg;
        pass_busy_next = pass_busy_reg;
        rd_idx_next = rd_idx_reg;
        rd_vld_next = 1'b0;
        pass_done_next = 1'b0;
        dev_next = dev_reg;
        dev_vld_next = 1'b0;
        sq_next = sq_reg;
        sq_vld_next = 1'b0;
        div_busy_next = div_busy_reg;
        div_done_next = 1'b0;
        div_cnt_next = div_cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        div_neg_next = div_neg_reg;
        div_var_next = div_var_reg;
        sqrt_busy_next = sqrt_busy_reg;
        sqrt_done_next = 1'b0;
        sqrt_cnt_next = sqrt_cnt_reg;
        rad_next = rad_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        std_next = std_reg;

        // sample transfer: store and accumulate, or flag a drop once the store is full
        if (keep)
        begin
            count_next = count_reg + 1'b1;
            sum_next = sum_reg + SUM_W'(in_data.sample);
        end
        else if (cmd.store)
        begin
            drop_next = 1'b1;
        end

        // restoring divider, one quotient bit per cycle
        if (cmd.div_start)
        begin
            div_busy_next = 1'b1;
            div_cnt_next = '0;
            rem_next = '0;
            div_var_next = cmd.div_var;
            if (cmd.div_var)
            begin
                quo_next = acc_reg;
                dvs_next = count_reg - 1'b1;
                div_neg_next = 1'b0;
            end
            else
            begin
                quo_next = ACC_W'(sum_mag);
                dvs_next = count_reg;
                div_neg_next = sum_reg[SUM_W-1];
            end
        end
        else if (div_busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub;
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + 1'b1;
            if (div_cnt_reg == 7'(DIV_STEPS - 1))
            begin
                div_busy_next = 1'b0;
                div_done_next = 1'b1;
            end
        end
        if (div_done_reg && !div_var_reg)
        begin
            mean_next = div_neg_reg ? -SUM_W'(quo_reg) : SUM_W'(quo_reg);
        end

        // deviation pass: read, subtract, square, accumulate
        if (cmd.pass_start)
        begin
            pass_busy_next = 1'b1;
            rd_idx_next = '0;
            acc_next = '0;
        end
        else if (pass_busy_reg)
        begin
            if (rd_idx_reg < count_reg)
            begin
                rd_vld_next = 1'b1;
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            else if (!rd_vld_reg && !dev_vld_reg && !sq_vld_reg)
            begin
                pass_busy_next = 1'b0;
                pass_done_next = 1'b1;
            end
        end
        if (rd_vld_reg)
        begin
            dev_next = (DEV_W+1)'($signed(ram_rdata)) - (DEV_W+1)'(mean_reg);
            dev_vld_next = 1'b1;
        end
        if (dev_vld_reg)
        begin
            sq_next = dev_mag * dev_mag;
            sq_vld_next = 1'b1;
        end
        if (sq_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(sq_reg);
        end

        // digit-by-digit square root, two radicand bits per cycle
        if (cmd.sqrt_start)
        begin
            sqrt_busy_next = 1'b1;
            sqrt_cnt_next = '0;
            rad_next = quo_reg;
            srem_next = '0;
            root_next = '0;
        end
        else if (sqrt_busy_reg)
        begin
            rad_next = {rad_reg[ACC_W-3:0], 2'b00};
            if (srem_shift >= trial)
            begin
                srem_next = srem_shift - trial;
                root_next = {root_reg[ACC_W/2-2:0], 1'b1};
            end
            else
            begin
                srem_next = srem_shift;
                root_next = {root_reg[ACC_W/2-2:0], 1'b0};
            end
            sqrt_cnt_next = sqrt_cnt_reg + 1'b1;
            if (sqrt_cnt_reg == 6'(SQRT_STEPS - 1))
            begin
                sqrt_busy_next = 1'b0;
                sqrt_done_next = 1'b1;
            end
        end
        if (sqrt_done_reg)
        begin
            std_next = (root_reg > (ACC_W/2)'({STD_W{1'b1}})) ? {STD_W{1'b1}}
                                                               : root_reg[STD_W-1:0];
        end

        // set closed and reported
        if (cmd.clear)
        begin
            count_next = '0;
            sum_next = '0;
            acc_next = '0;
            drop_next = 1'b0;
            std_next = '0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg <= '0;
            acc_reg <= '0;
            drop_reg <= 1'b0;
            pass_busy_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            pass_done_reg <= 1'b0;
            dev_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            sqrt_busy_reg <= 1'b0;
            sqrt_done_reg <= 1'b0;
            std_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg <= sum_next;
            acc_reg <= acc_next;
            drop_reg <= drop_next;
            pass_busy_reg <= pass_busy_next;
            rd_vld_reg <= rd_vld_next;
            pass_done_reg <= pass_done_next;
            dev_vld_reg <= dev_vld_next;
            sq_vld_reg <= sq_vld_next;
            div_busy_reg <= div_busy_next;
            div_done_reg <= div_done_next;
            sqrt_busy_reg <= sqrt_busy_next;
            sqrt_done_reg <= sqrt_done_next;
            std_reg <= std_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        rd_idx_reg <= rd_idx_next;
        dev_reg <= dev_next;
        sq_reg <= sq_next;
        div_cnt_reg <= div_cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        div_neg_reg <= div_neg_next;
        div_var_reg <= div_var_next;
        sqrt_cnt_reg <= sqrt_cnt_next;
        rad_reg <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign stat.div_done = div_done_reg;
    assign stat.pass_done = pass_done_reg;
    assign stat.sqrt_done = sqrt_done_reg;
    assign stat.enough = (count_reg >= COUNT_W'(2));

    assign res.std_dev = std_reg;
    assign res.sample_count = count_reg;
    assign res.overflow = drop_reg;

endmodule

FILE: src/ssd_ctrl.sv
// controller state machine for the sample standard deviation block
// depends on ssd_pkg
module ssd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    input  logic               out_stall,
    input  ssd_pkg::ssd_stat_t stat,
    output ssd_pkg::ssd_cmd_t  cmd,
    output logic               in_stall,
    output logic               out_valid,
    output logic               out_load
);
    import ssd_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_MEAN, S_PASS, S_VAR, S_ROOT, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic in_take;

    assign in_take = in_valid && !in_stall;
    assign in_stall = (state_reg != S_LOAD);
    assign out_valid = out_valid_reg;

    // load; 2+ samples: mean div, deviation pass, var div, root; output
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        out_load = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.store = in_take;
                if (in_take && in_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.enough)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_MEAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MEAN:
            begin
                if (stat.div_done)
                begin
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                cmd.pass_start = 1'b1;
                state_next = S_VAR;
            end
            S_VAR:
            begin
                if (stat.pass_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_var = 1'b1;
                end
                if (stat.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    out_valid_next = 1'b1;
                    cmd.clear = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/sample_standard_deviation.sv
// top level of the sample standard deviation block
// depends on ssd_pkg, ssd_ctrl, ssd_datapath, ssd_ram
//
//  channel | direction | signals
//  in      | input     | in_valid, in_stall, in_data (sample, last)
//  out     | output    | out_valid, out_stall, out_data (std_dev, sample_count, overflow)
//
// samples transfer one per cycle while a set loads; the store is one ram port
// after the last sample: mean divide, deviation pass, variance divide and
// square root; a set of under two samples goes straight to the output
// the result sits in an output register; the next set loads while it waits
// a finished set waits before the output register only while it is still full
// reset is asynchronous active low and clears counts, sums and flags
module sample_standard_deviation #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ssd_pkg::ssd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ssd_pkg::ssd_out_t out_data
);
    import ssd_pkg::*;

    ssd_cmd_t cmd;
    ssd_stat_t stat;
    ssd_out_t res;
    ssd_out_t out_data_reg;
    logic out_load;

    ssd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_load  (out_load)
    );

    ssd_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .res     (res)
    );

    // output register, loaded as the set closes
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_data = out_data_reg;

endmodule
